/* rtl/selective_repeat_receiver_core_defines.svh */
// Assertion macros for the selective-repeat receiver.
// Used by the top level only; define ASSERT_OFF to compile them out.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("srr: invariant violated");
`define SRR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srr: implication violated");
`else
`define SRR_ASSERT(label, prop)
`define SRR_ASSERT_IMP(label, ante, cons)
`endif
`endif

/* rtl/srr_pkg.sv */
// Shared types and constants for the selective-repeat receiver.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package srr_pkg;

  localparam int unsigned WINDOW_MAX_DEF    = 16;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned SEQ_LIMIT         = 1024;

  localparam int unsigned SEQ_W      = 10;
  localparam int unsigned BASE_W     = 11;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned ACK_W      = 11;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SEQ_W-1:0]        INITIAL_BASE_RST = '0;
  localparam logic [WIN_W-1:0]        WINDOW_SIZE_RST  = 5'd4;
  localparam logic signed [ACK_W-1:0] ACK_NONE         = -11'sd1;

  // register index codes (paddr[2])
  localparam logic REG_INITIAL_BASE = 1'b0;
  localparam logic REG_WINDOW_SIZE  = 1'b1;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef enum logic {
    OP_BAD  = 1'b0,
    OP_GOOD = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              restart;
    logic [BASE_W-1:0] init_base;
    logic [WIN_W-1:0]  win;
  } cfg_t;

endpackage

/* rtl/srr_ifs.sv */
// Request channel interfaces: incoming packets and outgoing results.
// Depends on srr_pkg for field widths.
interface srr_pkt_if;
  logic                            valid;
  logic                            ready;
  logic                            checksum_ok;
  logic [srr_pkg::SEQ_W-1:0]       seq_num;
  logic [srr_pkg::DATA_W-1:0]      payload;
  modport source (output valid, checksum_ok, seq_num, payload, input ready);
  modport sink   (input valid, checksum_ok, seq_num, payload, output ready);
endinterface

interface srr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic signed [srr_pkg::ACK_W-1:0] ack_num;
  logic [srr_pkg::DATA_W-1:0]      data_out;
  logic                            last;
  modport source (output valid, kind, ack_num, data_out, last, input ready);
  modport sink   (input valid, kind, ack_num, data_out, last, output ready);
endinterface

/* rtl/srr_front.sv */
// Front stage: takes packet requests, classifies checksum, masks payload.
// Depends on srr_pkg and srr_pkt_if.
module srr_front #(
  parameter int unsigned PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  srr_pkt_if.sink            pkt,
  output srr_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  logic               cmd_ready
);

  localparam logic [srr_pkg::DATA_W-1:0] PAYLOAD_MASK =
    {srr_pkg::DATA_W{1'b1}} >> (srr_pkg::DATA_W - 8 * PAYLOAD_BYTES);

  logic          st_valid;
  srr_pkg::cmd_t st_cmd;

  assign pkt.ready = !st_valid || cmd_ready;
  assign cmd_valid = st_valid;
  assign cmd       = st_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (pkt.ready) begin
      st_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      st_cmd.op   <= pkt.checksum_ok ? srr_pkg::OP_GOOD : srr_pkg::OP_BAD;
      st_cmd.seq  <= pkt.seq_num;
      st_cmd.data <= pkt.payload & PAYLOAD_MASK;
    end
  end

endmodule

/* rtl/srr_queue.sv */
// Short command queue between the front and back parts.
// Depends on srr_pkg.
module srr_queue (
  input  logic          clk,
  input  logic          rst,
  input  srr_pkg::cmd_t in_cmd,
  input  logic          in_valid,
  output logic          in_ready,
  output srr_pkg::cmd_t out_cmd,
  output logic          out_valid,
  input  logic          out_ready
);

  srr_pkg::cmd_t                entry [srr_pkg::QUEUE_DEPTH];
  logic [srr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [srr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [srr_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign in_ready  = count != srr_pkg::QCNT_W'(srr_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == srr_pkg::QPTR_W'(srr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == srr_pkg::QPTR_W'(srr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/srr_back.sv */
// Back part: window test, reorder buffer, in-order drain and result register.
// Depends on srr_pkg and srr_rsp_if.
module srr_back #(
  parameter int unsigned WINDOW_MAX = srr_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  srr_pkg::cfg_t                cfg,
  input  srr_pkg::cmd_t                cmd,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  srr_rsp_if.source                    rsp,
  output logic [srr_pkg::BASE_W-1:0]   base_out
);

  localparam int unsigned IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned WIN_CAP = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
  localparam int unsigned BASE_W  = srr_pkg::BASE_W;
  localparam int unsigned ACK_W   = srr_pkg::ACK_W;
  localparam int unsigned DATA_W  = srr_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DELIV = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [BASE_W-1:0]        base;
  logic [IDX_W-1:0]         head;
  logic [WINDOW_MAX-1:0]    filled;
  logic signed [ACK_W-1:0]  last_ack;
  srr_pkg::cmd_t            cur;
  logic [DATA_W-1:0]        slot_payload [WINDOW_MAX];
  logic [DATA_W-1:0]        rd_data;

  logic                     out_valid;
  logic                     out_kind;
  logic signed [ACK_W-1:0]  out_ack;
  logic [DATA_W-1:0]        out_data;
  logic                     out_last;

  logic                     out_free;
  logic                     pop;
  logic                     emit;
  logic                     e_kind;
  logic signed [ACK_W-1:0]  e_ack;
  logic [DATA_W-1:0]        e_data;
  logic                     e_last;
  logic                     do_store;
  logic                     do_take;
  logic                     set_ack;

  logic [srr_pkg::WIN_W-1:0] win_eff;
  logic [BASE_W-1:0]        seq_ext;
  logic [BASE_W-1:0]        win_end;
  logic [BASE_W-1:0]        offset;
  logic [IDX_W:0]           slot_sum;
  logic [IDX_W-1:0]         slot;
  logic [IDX_W-1:0]         head_inc;
  logic signed [ACK_W-1:0]  seq_ack;

  assign win_eff  = (cfg.win > srr_pkg::WIN_W'(WIN_CAP)) ? srr_pkg::WIN_W'(WIN_CAP) : cfg.win;
  assign seq_ext  = {1'b0, cur.seq};
  assign seq_ack  = $signed({1'b0, cur.seq});
  assign win_end  = base + BASE_W'(win_eff);
  assign offset   = seq_ext - base;
  // circular slot: head tracks base, so base+offset maps to head+offset
  assign slot_sum = {1'b0, head} + {1'b0, offset[IDX_W-1:0]};
  assign slot     = (slot_sum >= (IDX_W+1)'(WINDOW_MAX)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(WINDOW_MAX)) : slot_sum[IDX_W-1:0];
  assign head_inc = (head == IDX_W'(WINDOW_MAX - 1)) ? '0 : head + 1'b1;

  assign out_free  = !out_valid || rsp.ready;
  assign cmd_ready = (state == S_IDLE);
  assign pop       = cmd_ready && cmd_valid;
  assign base_out  = base;

  assign rsp.valid    = out_valid;
  assign rsp.kind     = out_kind;
  assign rsp.ack_num  = out_ack;
  assign rsp.data_out = out_data;
  assign rsp.last     = out_last;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_kind     = srr_pkg::KIND_ACK;
    e_ack      = last_ack;
    e_data     = '0;
    e_last     = 1'b1;
    do_store   = 1'b0;
    do_take    = 1'b0;
    set_ack    = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur.op == srr_pkg::OP_BAD) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (seq_ext >= win_end) begin
          state_next = S_IDLE;
        end else if (seq_ext < base) begin
          if (out_free) begin
            emit       = 1'b1;
            e_ack      = seq_ack;
            set_ack    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          do_store   = 1'b1;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (base >= BASE_W'(srr_pkg::SEQ_LIMIT) || !filled[head]) begin
          if (out_free) begin
            emit       = 1'b1;
            e_ack      = seq_ack;
            set_ack    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          do_take    = 1'b1;
          state_next = S_DELIV;
        end
      end
      S_DELIV: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = srr_pkg::KIND_DATA;
          e_ack      = $signed(base - BASE_W'(1));
          e_data     = rd_data;
          e_last     = 1'b0;
          state_next = S_DRAIN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= {1'b0, srr_pkg::INITIAL_BASE_RST};
      head      <= '0;
      filled    <= '0;
      last_ack  <= srr_pkg::ACK_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.restart) begin
        base     <= cfg.init_base;
        head     <= '0;
        filled   <= '0;
        last_ack <= srr_pkg::ACK_NONE;
      end else begin
        if (do_store) begin
          filled[slot] <= 1'b1;
        end
        if (do_take) begin
          filled[head] <= 1'b0;
          base         <= base + BASE_W'(1);
          head         <= head_inc;
        end
        if (set_ack) begin
          last_ack <= seq_ack;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (do_store) begin
      slot_payload[slot] <= cur.data;
    end
    if (do_take) begin
      rd_data <= slot_payload[head];
    end
    if (emit) begin
      out_kind <= e_kind;
      out_ack  <= e_ack;
      out_data <= e_data;
      out_last <= e_last;
    end
  end

endmodule

/* rtl/selective_repeat_receiver_core.sv */
// Selective-repeat receiver. A bad checksum or an ack below the window gives one ack result;
// a stored packet acks after it releases its n payloads, each delivered as a result of its
// own before the ack. Dropped packets give no result.
// The back part holds one packet at a time until its final result is emitted, with one
// reorder-buffer read and one result per delivery. Front accepts while queue has room.
// Reset: synchronous, active high; registers to defaults, buffer marked empty at once.
`include "selective_repeat_receiver_core_defines.svh"
module selective_repeat_receiver_core #(
  parameter int unsigned WINDOW_MAX    = srr_pkg::WINDOW_MAX_DEF,
  parameter int unsigned PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [srr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [srr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // request channels
  srr_pkt_if.sink                           pkt,
  srr_rsp_if.source                         rsp
);

  localparam int unsigned BASE_W = srr_pkg::BASE_W;

  logic [srr_pkg::SEQ_W-1:0] initial_base;
  logic [srr_pkg::WIN_W-1:0] window_size;
  logic                      cfg_wr;
  logic [BASE_W-1:0]         wr_base;
  srr_pkg::cfg_t             cfg;

  srr_pkg::cmd_t             f_cmd;
  logic                      f_valid;
  logic                      f_ready;
  srr_pkg::cmd_t             q_cmd;
  logic                      q_valid;
  logic                      q_ready;
  logic [BASE_W-1:0]         base;

  // ---- configuration registers ----
  // Register index is paddr[2]; writing initial_base restarts the receiver
  // in the same edge, using the written value directly.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_base = ({1'b0, pwdata[srr_pkg::SEQ_W-1:0]} > BASE_W'(srr_pkg::SEQ_LIMIT)) ?
                   BASE_W'(srr_pkg::SEQ_LIMIT) : {1'b0, pwdata[srr_pkg::SEQ_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_base <= srr_pkg::INITIAL_BASE_RST;
      window_size  <= srr_pkg::WINDOW_SIZE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        srr_pkg::REG_INITIAL_BASE: initial_base <= pwdata[srr_pkg::SEQ_W-1:0];
        srr_pkg::REG_WINDOW_SIZE:  window_size  <= pwdata[srr_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srr_pkg::REG_INITIAL_BASE:
        prdata = srr_pkg::APB_DATA_W'(initial_base);
      srr_pkg::REG_WINDOW_SIZE:
        prdata = srr_pkg::APB_DATA_W'(window_size);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.restart   = cfg_wr && (paddr[2] == srr_pkg::REG_INITIAL_BASE);
  assign cfg.init_base = wr_base;
  assign cfg.win       = window_size;

  // ---- front: accept and classify ----
  srr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  // ---- decoupling queue ----
  srr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (f_cmd),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_cmd   (q_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  // ---- back: window, reorder buffer, drain, results ----
  srr_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .rsp       (rsp),
    .base_out  (base)
  );

  // ---- assertions ----
  // a delivery is never the final result of a packet
  `SRR_ASSERT_IMP(a_data_not_last, rsp.valid && (rsp.kind == srr_pkg::KIND_DATA), !rsp.last)
  // a delivery carries a real sequence number
  `SRR_ASSERT_IMP(a_data_num_pos, rsp.valid && (rsp.kind == srr_pkg::KIND_DATA), !rsp.ack_num[10])
  // window base stays within the sequence space
  `SRR_ASSERT(a_base_limit, base <= BASE_W'(srr_pkg::SEQ_LIMIT))
  // base only moves forward, unless restarted
  `SRR_ASSERT_IMP(a_base_fwd, !$past(rst) && !$past(cfg.restart), base >= $past(base))

endmodule

/* tb/sv/srr_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the selective-repeat receiver: watches packet, result and register traffic,
// keeps its own window state and checks every result in order.
// Depends on srr_pkg and the channel interfaces in srr_ifs.sv.
module srr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [srr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [srr_pkg::APB_DATA_W-1:0] pwdata,
  srr_pkt_if                            pkt,
  srr_rsp_if                            rsp,
  output int                            errors,
  output int                            pending,
  output int                            pkts_seen,
  output int                            results_seen
);
  import srr_pkg::*;

  localparam int SLOTS     = WINDOW_MAX_DEF;
  localparam int SEQ_SPACE = SEQ_LIMIT;

  typedef struct {
    logic                    kind;
    logic signed [ACK_W-1:0] ack_num;
    logic [DATA_W-1:0]       data_out;
    logic                    last;
  } result_t;

  logic [SEQ_W-1:0]        base_reg;
  logic [WIN_W-1:0]        win_reg;
  int                      win_base;
  logic                    slot_full [SLOTS];
  logic [DATA_W-1:0]       slot_data [SLOTS];
  logic signed [ACK_W-1:0] last_ack_num;
  result_t                 due_results [$];
  int                      err_cnt = 0;
  int                      pkt_cnt = 0;
  int                      rsp_cnt = 0;

  function automatic result_t make_result(logic kind, logic signed [ACK_W-1:0] num,
                                          logic [DATA_W-1:0] data, logic last);
    result_t r;
    r.kind     = kind;
    r.ack_num  = num;
    r.data_out = data;
    r.last     = last;
    return r;
  endfunction

  task automatic restart_window();
    win_base = int'(base_reg);
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    last_ack_num = ACK_NONE;
  endtask

  // expected results of one accepted packet request
  task automatic receive_packet(logic ok, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
    int win_eff;
    int b;
    win_eff = (int'(win_reg) > SLOTS) ? SLOTS : int'(win_reg);
    if (ok !== OP_GOOD) begin
      due_results.push_back(make_result(KIND_ACK, last_ack_num, '0, 1'b1));
      return;
    end
    if (int'(seq) >= win_base + win_eff) return;
    if (int'(seq) >= win_base) begin
      slot_data[int'(seq) % SLOTS] = data;
      slot_full[int'(seq) % SLOTS] = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (win_base >= SEQ_SPACE) break;
        b = win_base % SLOTS;
        if (!slot_full[b]) break;
        due_results.push_back(make_result(KIND_DATA, ACK_W'(win_base), slot_data[b], 1'b0));
        slot_full[b] = 1'b0;
        win_base++;
      end
    end
    last_ack_num = ACK_W'(int'(seq));
    due_results.push_back(make_result(KIND_ACK, last_ack_num, '0, 1'b1));
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = make_result(rsp.kind, rsp.ack_num, rsp.data_out, rsp.last);
    rsp_cnt++;
    if (due_results.size() == 0) begin
      if (err_cnt < 10)
        $display("[%0t] unexpected result: kind=%0d ack=%0d data=%h last=%0d", $realtime,
                 got.kind, got.ack_num, got.data_out, got.last);
      err_cnt++;
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.ack_num !== want.ack_num ||
          got.data_out !== want.data_out || got.last !== want.last) begin
        if (err_cnt < 10) begin
          $display("[%0t] mismatch: exp kind=%0d ack=%0d data=%h last=%0d", $realtime,
                   want.kind, want.ack_num, want.data_out, want.last);
          $display("                got kind=%0d ack=%0d data=%h last=%0d",
                   got.kind, got.ack_num, got.data_out, got.last);
        end
        err_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base_reg = INITIAL_BASE_RST;
      win_reg  = WINDOW_SIZE_RST;
      restart_window();
      due_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_result();
      if (pkt.valid && pkt.ready) begin
        pkt_cnt++;
        receive_packet(pkt.checksum_ok, pkt.seq_num, pkt.payload);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_INITIAL_BASE) begin
          base_reg = pwdata[SEQ_W-1:0];
          restart_window();
        end else begin
          win_reg = pwdata[WIN_W-1:0];
        end
      end
    end
    errors       <= err_cnt;
    pending      <= due_results.size();
    pkts_seen    <= pkt_cnt;
    results_seen <= rsp_cnt;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the selective-repeat receiver: clock, reset, packet and register
// stimulus, result back-pressure and the verdict. Depends on srr_pkg, srr_ifs.sv,
// selective_repeat_receiver_core and srr_checker.
module tb_top;
  import srr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000; // far above the slowest legal run
  localparam int SETTLE_CYCLES = 64;     // lets dropped packets clear the front, queue and back part
  localparam int LONG_HOLD     = 300;    // result stall long enough to back up the input
  localparam int PHASE_ITEMS   = 58;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  srr_pkt_if pkt_ch ();
  srr_rsp_if rsp_ch ();

  int errors;
  int pending;
  int pkts_seen;
  int results_seen;
  int reg_writes = 0;
  int rd_errors  = 0;
  int cycle_cnt  = 0;
  int hold_reqs  = 0;  // raised by stimulus, served by the result-side process
  int hold_done  = 0;
  bit calm       = 1'b0; // no idling on either side when set

  selective_repeat_receiver_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pkt     (pkt_ch),
    .rsp     (rsp_ch)
  );

  srr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pkt          (pkt_ch),
    .rsp          (rsp_ch),
    .errors       (errors),
    .pending      (pending),
    .pkts_seen    (pkts_seen),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_cnt, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, a long stall on request, none when calm.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        rsp_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done++;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // One packet request; may open with an idle burst. Returns at the accepting edge,
  // leaving valid high so back-to-back requests follow without a gap.
  task automatic send_packet(op_t op, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      @(negedge clk);
      pkt_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pkt_ch.valid       = 1'b1;
    pkt_ch.checksum_ok = op;
    pkt_ch.seq_num     = seq;
    pkt_ch.payload     = data;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready; then read the register back
  task automatic reg_write(logic idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] want;
    want = (idx == REG_INITIAL_BASE) ? APB_DATA_W'(value[SEQ_W-1:0]) :
                                       APB_DATA_W'(value[WIN_W-1:0]);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
    // read back
    @(negedge clk);
    psel    = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      if (rd_errors < 10)
        $display("[%0t] register read: exp %h got %h", $realtime, want, prdata);
      rd_errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Stop offering, wait for every outstanding result, then let dropped packets clear.
  task automatic drain();
    @(negedge clk);
    pkt_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random phase. Mostly well-formed traffic: consecutive numbers from the base sent in
  // shuffled blocks of one window, so every block is stored and then flushed. Mixed in:
  // bad checksums, stray numbers anywhere in the space and repeats of numbers already sent.
  task automatic run_phase(logic [SEQ_W-1:0] base, logic [WIN_W-1:0] win, bit long_hold,
                           bit mid_pause);
    int chunk [WINDOW_MAX_DEF];
    int clen;
    int ci;
    int cb;
    int w;
    int r;
    int j;
    int tmp;
    drain();
    reg_write(REG_INITIAL_BASE, APB_DATA_W'(base));
    reg_write(REG_WINDOW_SIZE, APB_DATA_W'(win));
    if (long_hold) hold_reqs++;
    w = (int'(win) > int'(WINDOW_MAX_DEF)) ? int'(WINDOW_MAX_DEF) : int'(win);
    if (w == 0) w = 1;
    cb   = int'(base);
    clen = 0;
    ci   = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // halfway through, if mid_pause is set, the sender waits for every result before carrying on
      if (mid_pause && n == PHASE_ITEMS / 2) drain();
      if (ci == clen && cb < int'(SEQ_LIMIT)) begin
        clen = (int'(SEQ_LIMIT) - cb < w) ? int'(SEQ_LIMIT) - cb : w;
        for (int k = 0; k < clen; k++) chunk[k] = cb + k;
        for (int k = clen - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = chunk[k];
          chunk[k] = chunk[j];
          chunk[j] = tmp;
        end
        cb += clen;
        ci  = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 12)
        send_packet(OP_BAD, SEQ_W'($urandom_range(0, SEQ_LIMIT - 1)), {$urandom, $urandom});
      else if (r < 20 || ci == clen)
        send_packet(OP_GOOD, SEQ_W'($urandom_range(0, SEQ_LIMIT - 1)), {$urandom, $urandom});
      else if (r < 27 && ci > 0)
        send_packet(OP_GOOD, SEQ_W'(chunk[$urandom_range(0, ci - 1)]), {$urandom, $urandom});
      else begin
        send_packet(OP_GOOD, SEQ_W'(chunk[ci]), {$urandom, $urandom});
        ci++;
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pkt_ch.valid       = 1'b0;
    pkt_ch.checksum_ok = 1'b0;
    pkt_ch.seq_num     = '0;
    pkt_ch.payload     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset settings: base 0, window 4 ---
    send_packet(OP_BAD, 10'd1023, {$urandom, $urandom});   // ack before any ack: minus one
    send_packet(OP_GOOD, 10'd2, {$urandom, $urandom});      // stored out of order
    send_packet(OP_GOOD, 10'd0, '1);                        // delivers 0 only
    send_packet(OP_GOOD, 10'd1, '0);                        // delivers 1 and 2
    send_packet(OP_GOOD, 10'd5, {$urandom, $urandom});
    send_packet(OP_GOOD, 10'd5, {$urandom, $urandom});      // duplicate overwrites slot
    send_packet(OP_GOOD, 10'd7, {$urandom, $urandom});      // window end: dropped
    send_packet(OP_GOOD, 10'd3, {$urandom, $urandom});
    send_packet(OP_GOOD, 10'd4, {$urandom, $urandom});      // delivers 4 and the new 5
    send_packet(OP_BAD, 10'd0, {$urandom, $urandom});       // resends last ack

    // window of zero: nothing at or above the base gets in
    drain();
    reg_write(REG_WINDOW_SIZE, 32'd0);
    send_packet(OP_GOOD, 10'd6, {$urandom, $urandom});      // at base: dropped
    send_packet(OP_GOOD, 10'd2, {$urandom, $urandom});      // below: ack only

    // oversize window saturates; fill all slots backwards so the last packet flushes
    // sixteen payloads and the base runs off the end of the sequence space
    drain();
    reg_write(REG_INITIAL_BASE, 32'd1008);
    reg_write(REG_WINDOW_SIZE, 32'd31);
    for (int s = 1023; s >= 1008; s--) send_packet(OP_GOOD, SEQ_W'(s), {$urandom, $urandom});
    send_packet(OP_GOOD, 10'd1023, {$urandom, $urandom});   // everything is below now

    // top base value
    drain();
    reg_write(REG_INITIAL_BASE, 32'd1023);
    send_packet(OP_GOOD, 10'd1023, '1);

    // --- random part ---
    run_phase(10'd0, 5'd16, 1'b1, 1'b0);                    // long result stall
    run_phase(SEQ_W'($urandom_range(0, 900)), 5'd1, 1'b0, 1'b0);
    run_phase(SEQ_W'($urandom_range(0, 900)), WIN_W'($urandom_range(2, 15)), 1'b0, 1'b1);
    run_phase(10'd1000, 5'd31, 1'b0, 1'b0);                 // runs into the end of the space
    run_phase(SEQ_W'($urandom_range(0, 900)), WIN_W'($urandom_range(17, 30)), 1'b0, 1'b0);
    calm = 1'b1;                                            // closing stretch at full rate
    run_phase(SEQ_W'($urandom_range(0, 900)), WIN_W'($urandom_range(1, 16)), 1'b0, 1'b0);

    drain();
    $display("Covered %0d packets, %0d results checked, %0d register writes read back.",
             pkts_seen, results_seen, reg_writes);
    $display("Windows 0, 1, mid and saturated; bases 0 to 1023; end of space; long stall.");
    if (errors == 0 && rd_errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/srr_pkg.sv
rtl/srr_ifs.sv
rtl/srr_front.sv
rtl/srr_queue.sv
rtl/srr_back.sv
rtl/selective_repeat_receiver_core.sv
tb/sv/srr_checker.sv
tb/sv/tb_top.sv
